@@ design/bah_pkg.sv @@
// Shared types, constants and a helper function of the bond angle histogram.
`default_nettype none

package bah_pkg;

  localparam int unsigned NUM_SPECIES_DEF = 4;
  localparam int unsigned MAX_BINS_DEF    = 256;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned WIDTH_W = 16;

  // 180/pi in Q6.24, so that angle (Q2.16) times this gives degrees in Q.40.
  localparam logic [29:0] DEG_PER_RAD = 30'd961263669;
  // 180 degrees in Q.40 plus a tolerance of 1e-5 degree.
  localparam logic [47:0] DEG_LIMIT   = 48'hB400_00A7_C5AC;
  // 180 degrees in Q8.8.
  localparam logic [47:0] SPAN        = 48'd46080;
  localparam logic [15:0] WIDTH_RESET = 16'd256;

  // Shared divider: numerator, divisor and quotient widths.
  localparam int unsigned DIV_NUM_W = 58;
  localparam int unsigned DIV_DEN_W = 49;
  localparam int unsigned DIV_Q_W   = 19;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ANGLE   = 2'd1,
    ST_SPECIES = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CS_SWEEP,
    CS_IDLE,
    CS_PREP,
    CS_CHECK,
    CS_LOADC,
    CS_DIV,
    CS_FETCH,
    CS_COMMIT,
    CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    action_e     action;
    logic [17:0] angle;
    logic [1:0]  species_center;
    logic [1:0]  species_first;
    logic [1:0]  species_second;
    logic        read_total;
    logic [7:0]  bin_index;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] bin_count;
    logic [31:0] grand_total;
    logic [17:0] density;
    logic [15:0] bin_center;
    logic        normalized;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic clear;
    logic check;
    logic div_start;
    logic load_count;
    logic fetch;
    logic commit;
    logic dens_store;
    logic finish;
    logic sweep;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    fail;
    logic    bin_bad;
    logic    total_zero;
    logic    div_busy;
    logic    sweep_last;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ design/bah_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module bah_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [bah_pkg::DIV_NUM_W-1:0]  num_i,
  input  wire logic [bah_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                                busy_o,
  output logic [bah_pkg::DIV_Q_W-1:0]         quot_o
);

  localparam int unsigned QW   = bah_pkg::DIV_Q_W;
  localparam int unsigned SH_W = bah_pkg::DIV_DEN_W + QW - 1;
  localparam int unsigned CW   = $clog2(QW + 1);

  logic            busy_q;
  logic [CW-1:0]   cnt_q;
  logic [SH_W-1:0] rem_q;
  logic [SH_W-1:0] dsh_q;
  logic [QW-1:0]   quot_q;
  logic            ge;
  logic [SH_W-1:0] diff;

  assign ge   = rem_q >= dsh_q;
  assign diff = rem_q - dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= SH_W'(num_i);
      dsh_q  <= SH_W'(den_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff;
      end
      quot_q <= {quot_q[QW-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ design/bah_dp.sv @@
// Datapath of the histogram: counter memories, multiplier, divider and result register.
`default_nettype none

module bah_dp #(
  parameter int unsigned NUM_SPECIES = bah_pkg::NUM_SPECIES_DEF,
  parameter int unsigned MAX_BINS    = bah_pkg::MAX_BINS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bah_pkg::cmd_t      cmd_i,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire bah_pkg::dp_cmd_t   ctl_i,
  output bah_pkg::dp_stat_t       stat_o,
  output logic                    done_o,
  output bah_pkg::res_t           res_o
);

  localparam int unsigned NT    = NUM_SPECIES * NUM_SPECIES * NUM_SPECIES;
  localparam int unsigned DEPTH = NT * MAX_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(MAX_BINS);
  localparam int unsigned TW    = (NT > 1) ? $clog2(NT) : 1;

  bah_pkg::cmd_t    cmd_q;
  logic [15:0]      width_q;
  logic [47:0]      prod_q;
  logic [47:0]      den_q;
  bah_pkg::status_e status_q;
  logic [31:0]      count_q;
  logic [17:0]      dens_q;
  logic [15:0]      centre_q;
  logic             norm_q;
  logic [31:0]      total_q;
  logic [AW-1:0]    addr_q;
  logic [BW-1:0]    bin_q;
  logic [AW-1:0]    sweep_q;
  logic [31:0]      part_rdata_q;
  logic [31:0]      tot_rdata_q;
  bah_pkg::res_t    res_q;
  logic             done_q;

  logic [31:0]      part_mem [DEPTH];
  logic [31:0]      tot_mem  [MAX_BINS];

  logic [15:0]      w_eff;
  logic             sp_ok;
  logic [TW-1:0]    tri_idx;
  logic [BW-1:0]    bin_adj;
  logic [BW-1:0]    rbin;
  logic [AW-1:0]    addr_d;
  bah_pkg::status_e status_chk;
  logic             bin_bad;
  logic [31:0]      count_sel;
  logic [29:0]      mul_a;
  logic [29:0]      mul_b;
  logic [24:0]      centre_sum;
  logic [15:0]      centre_sat;
  logic [bah_pkg::DIV_NUM_W-1:0] div_num;
  logic [bah_pkg::DIV_DEN_W-1:0] div_den;
  logic [bah_pkg::DIV_Q_W-1:0]   quot;
  logic             div_busy;
  logic             sweep_last;
  logic             part_we;
  logic [AW-1:0]    part_waddr;
  logic [31:0]      part_wdata;
  logic             tot_we;
  logic [BW-1:0]    tot_waddr;
  logic [31:0]      tot_wdata;

  assign w_eff = (width_q == 16'd0) ? 16'd1 : width_q;

  assign sp_ok = (32'(cmd_q.species_center) < NUM_SPECIES) &&
                 (32'(cmd_q.species_first)  < NUM_SPECIES) &&
                 (32'(cmd_q.species_second) < NUM_SPECIES) &&
                 (cmd_q.species_second >= cmd_q.species_first);

  assign tri_idx = TW'((32'(cmd_q.species_center) * NUM_SPECIES
                        + 32'(cmd_q.species_first)) * NUM_SPECIES
                       + 32'(cmd_q.species_second));

  // An angle of exactly the last edge lands one past the bins; it folds into the last bin.
  assign bin_bad = 32'(quot) > MAX_BINS;
  assign bin_adj = (32'(quot) == MAX_BINS) ? BW'(MAX_BINS - 1) : BW'(quot);
  assign rbin    = (cmd_q.action == bah_pkg::ACT_READ) ? BW'(cmd_q.bin_index) : bin_adj;
  assign addr_d  = AW'(32'(tri_idx) * MAX_BINS + 32'(rbin));

  always_comb begin
    status_chk = bah_pkg::ST_OK;
    if (cmd_q.action == bah_pkg::ACT_ADD) begin
      if (!sp_ok) begin
        status_chk = bah_pkg::ST_SPECIES;
      end else if (prod_q > bah_pkg::DEG_LIMIT) begin
        status_chk = bah_pkg::ST_ANGLE;
      end
    end else begin
      if (!cmd_q.read_total && !sp_ok) begin
        status_chk = bah_pkg::ST_SPECIES;
      end else if ((32'(cmd_q.bin_index) >= MAX_BINS) || (prod_q > bah_pkg::SPAN)) begin
        status_chk = bah_pkg::ST_RANGE;
      end
    end
  end

  // Bin centre is index*width plus half the width, rounded up.
  assign centre_sum = 25'(prod_q[23:0]) + 25'(w_eff[15:1]) + 25'(w_eff[0]);
  assign centre_sat = (|centre_sum[24:16]) ? 16'hFFFF : centre_sum[15:0];

  assign count_sel = cmd_q.read_total ? tot_rdata_q : part_rdata_q;

  assign mul_a = (cmd_q.action == bah_pkg::ACT_ADD) ? 30'(cmd_q.angle)
                                                     : 30'(cmd_q.bin_index);
  assign mul_b = (cmd_q.action == bah_pkg::ACT_ADD) ? bah_pkg::DEG_PER_RAD : 30'(w_eff);

  always_comb begin
    if (cmd_q.action == bah_pkg::ACT_ADD) begin
      div_num = bah_pkg::DIV_NUM_W'(prod_q[47:32]);
      div_den = bah_pkg::DIV_DEN_W'(w_eff);
    end else begin
      div_num = bah_pkg::DIV_NUM_W'({count_sel, 25'd0}) + bah_pkg::DIV_NUM_W'(den_q);
      div_den = {den_q, 1'b0};
    end
  end

  bah_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign sweep_last = sweep_q == AW'(DEPTH - 1);

  assign part_we    = ctl_i.sweep || ctl_i.commit;
  assign part_waddr = ctl_i.sweep ? sweep_q : addr_q;
  assign part_wdata = ctl_i.sweep ? 32'd0 : bah_pkg::sat_inc(part_rdata_q);
  assign tot_we     = (ctl_i.sweep && (32'(sweep_q) < MAX_BINS)) || ctl_i.commit;
  assign tot_waddr  = ctl_i.sweep ? BW'(sweep_q) : bin_q;
  assign tot_wdata  = ctl_i.sweep ? 32'd0 : bah_pkg::sat_inc(tot_rdata_q);

  always_ff @(posedge clk_i) begin
    if (part_we) begin
      part_mem[part_waddr] <= part_wdata;
    end
    part_rdata_q <= part_mem[addr_d];
  end

  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    tot_rdata_q <= tot_mem[rbin];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= bah_pkg::WIDTH_RESET;
      total_q <= '0;
      sweep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_data_i;
      end
      if (ctl_i.clear) begin
        total_q <= '0;
      end else if (ctl_i.commit) begin
        total_q <= bah_pkg::sat_inc(total_q);
      end
      if (ctl_i.sweep) begin
        sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
      end
      done_q <= ctl_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= cmd_i;
      status_q <= bah_pkg::ST_OK;
      count_q  <= '0;
      dens_q   <= '0;
      centre_q <= '0;
      norm_q   <= 1'b0;
    end
    if (ctl_i.prep) begin
      prod_q <= 48'(mul_a) * 48'(mul_b);
    end
    if (ctl_i.check) begin
      status_q <= status_chk;
      den_q    <= 48'(total_q) * 48'(w_eff);
      if (cmd_q.action == bah_pkg::ACT_READ && status_chk == bah_pkg::ST_OK) begin
        centre_q <= centre_sat;
      end
    end
    if (ctl_i.load_count) begin
      count_q <= count_sel;
    end
    if (ctl_i.dens_store) begin
      dens_q <= quot[bah_pkg::DIV_Q_W-1] ? 18'h3FFFF : quot[17:0];
      norm_q <= 1'b1;
    end
    if (ctl_i.fetch) begin
      addr_q <= addr_d;
      bin_q  <= rbin;
      if (bin_bad) begin
        status_q <= bah_pkg::ST_RANGE;
      end
    end
    if (ctl_i.finish) begin
      res_q.status      <= status_q;
      res_q.bin_count   <= count_q;
      res_q.grand_total <= total_q;
      res_q.density     <= dens_q;
      res_q.bin_center  <= centre_q;
      res_q.normalized  <= norm_q;
    end
  end

  assign stat_o.action     = cmd_q.action;
  assign stat_o.fail       = status_chk != bah_pkg::ST_OK;
  assign stat_o.bin_bad    = bin_bad;
  assign stat_o.total_zero = total_q == 32'd0;
  assign stat_o.div_busy   = div_busy;
  assign stat_o.sweep_last = sweep_last;

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ design/bah_ctrl.sv @@
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none

module bah_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire bah_pkg::dp_stat_t stat_i,
  output bah_pkg::dp_cmd_t       cmd_o,
  output logic                   busy_o
);

  bah_pkg::ctrl_state_e state_q;
  bah_pkg::ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bah_pkg::CS_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bah_pkg::CS_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = bah_pkg::CS_IDLE;
        end
      end
      bah_pkg::CS_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = bah_pkg::CS_PREP;
        end
      end
      bah_pkg::CS_PREP: begin
        cmd_o.prep = 1'b1;
        if (stat_i.action == bah_pkg::ACT_ADD || stat_i.action == bah_pkg::ACT_READ) begin
          state_d = bah_pkg::CS_CHECK;
        end else begin
          cmd_o.clear = stat_i.action == bah_pkg::ACT_CLEAR;
          state_d     = bah_pkg::CS_FINISH;
        end
      end
      bah_pkg::CS_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.fail) begin
          state_d = bah_pkg::CS_FINISH;
        end else if (stat_i.action == bah_pkg::ACT_ADD) begin
          cmd_o.div_start = 1'b1;
          state_d         = bah_pkg::CS_DIV;
        end else begin
          state_d = bah_pkg::CS_LOADC;
        end
      end
      bah_pkg::CS_LOADC: begin
        cmd_o.load_count = 1'b1;
        if (stat_i.total_zero) begin
          state_d = bah_pkg::CS_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = bah_pkg::CS_DIV;
        end
      end
      bah_pkg::CS_DIV: begin
        if (!stat_i.div_busy) begin
          if (stat_i.action == bah_pkg::ACT_ADD) begin
            state_d = bah_pkg::CS_FETCH;
          end else begin
            cmd_o.dens_store = 1'b1;
            state_d          = bah_pkg::CS_FINISH;
          end
        end
      end
      bah_pkg::CS_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = stat_i.bin_bad ? bah_pkg::CS_FINISH : bah_pkg::CS_COMMIT;
      end
      bah_pkg::CS_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = bah_pkg::CS_FINISH;
      end
      bah_pkg::CS_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = (stat_i.action == bah_pkg::ACT_CLEAR) ? bah_pkg::CS_SWEEP : bah_pkg::CS_IDLE;
      end
      default: begin
        state_d = bah_pkg::CS_IDLE;
      end
    endcase
  end

  assign busy_o = state_q != bah_pkg::CS_IDLE;

endmodule

`default_nettype wire

@@ design/bond_angle_histogram.sv @@
// Top level of the bond angle histogram: controller, datapath and checks.
// An add divides its angle by the bin width in the 19-step shared divider; a read divides its
// count to a density there too, but skips the divider at a zero total. Species or angle
// drops, out-of-range reads, clears and no-ops skip the divider. The next transaction is
// taken at the same edge that takes the result. Reset and each clear run a clearing pass
// over all NUM_SPECIES^3 * MAX_BINS counters with busy high; no result stalls.
`default_nettype none

module bond_angle_histogram #(
  parameter int unsigned NUM_SPECIES = bah_pkg::NUM_SPECIES_DEF,
  parameter int unsigned MAX_BINS    = bah_pkg::MAX_BINS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Command channel: a transaction is taken when start is high and busy is low.
  input  wire logic          start,
  output logic               busy,
  input  wire bah_pkg::cmd_t cmd_i,
  // Result channel: one result per transaction, valid while done_o is high.
  output logic               done_o,
  output bah_pkg::res_t      res_o,
  // Configuration channel for the bin width register (Q8.8 degrees).
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [15:0]   cfg_data_i
);

  bah_pkg::dp_cmd_t  dp_cmd;
  bah_pkg::dp_stat_t dp_stat;
  logic              cfg_we;

  // The bin width register is always writable, also during the clearing pass.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // The controller walks each transaction through those of the prepare, check, count load,
  // divide, fetch and commit steps that it needs; the datapath holds the counter memories,
  // the shared multiplier and divider, the bin width register and the result register.
  bah_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy_o (busy)
  );

  bah_dp #(
    .NUM_SPECIES (NUM_SPECIES),
    .MAX_BINS    (MAX_BINS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (dp_cmd),
    .stat_o     (dp_stat),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transaction accepted but block not busy");

  // Two results never come back to back: each needs at least a load and a prepare step.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A dropped or out-of-range transaction reports no count and no density.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != bah_pkg::ST_OK |->
      res_o.bin_count == 32'd0 && res_o.normalized == 1'b0 && res_o.density == 18'd0)
    else $error("failed transaction carries read data");

  // A normalized density is only reported with a nonzero grand total.
  a_norm_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.normalized |-> res_o.grand_total != 32'd0)
    else $error("density normalized with zero total");

endmodule

`default_nettype wire
